### design/lapl_pkg.sv
// Shared types and constants for the 3x3 Laplacian RGB edge filter.
// No dependencies; used by the line store, the channel lanes and the top level.
package lapl_pkg;

    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 11;   // sum of eight 8-bit values, also 8*center
    localparam int SIZE_W      = 11;   // image size registers
    localparam int ROW_W       = 11;   // row counter, runs to height+1 while draining
    localparam int CFG_IDX_W   = 2;

    localparam logic [SIZE_W-1:0] MIN_SIZE     = 11'd3;
    localparam int                HEIGHT_LIMIT = 1024;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // one channel of the 3x3 window, row-major, entry 4 is the center
    typedef logic [8:0][CHAN_W-1:0] chan_win_t;

    typedef struct packed {
        logic load;
        logic border;
    } lane_ctl_t;

endpackage

### design/lapl_line_store.sv
// Two line stores (previous row, row before that), one read and one write port each.
// Depends on lapl_pkg for the pixel type.
module lapl_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  lapl_pkg::pixel_t wr_pix,
    output lapl_pkg::pixel_t top_pix,
    output lapl_pkg::pixel_t mid_pix
);

    lapl_pkg::pixel_t prev_mem  [DEPTH];
    lapl_pkg::pixel_t older_mem [DEPTH];
    lapl_pkg::pixel_t top_reg;
    lapl_pkg::pixel_t mid_reg;

    // read at accept; the write of the same beat uses the mid value read then
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            top_reg <= older_mem[rd_addr];
            mid_reg <= prev_mem[rd_addr];
        end
        if (wr_en) begin
            older_mem[wr_addr] <= mid_reg;
            prev_mem[wr_addr]  <= wr_pix;
        end
    end

    assign top_pix = top_reg;
    assign mid_pix = mid_reg;

endmodule

### design/lapl_lane.sv
// One color channel of the filter: 8*center minus neighbors, clamped, or border pass.
// Depends on lapl_pkg for window and control types.
module lapl_lane (
    input  logic                         aclk,
    input  lapl_pkg::lane_ctl_t          ctl,
    input  lapl_pkg::chan_win_t          win,
    output logic [lapl_pkg::CHAN_W-1:0]  pix_out
);

    logic [lapl_pkg::SUM_W-1:0]  nb_sum;
    logic [lapl_pkg::SUM_W-1:0]  center_x8;
    logic [lapl_pkg::SUM_W-1:0]  diff;
    logic [lapl_pkg::CHAN_W-1:0] filt;
    logic [lapl_pkg::CHAN_W-1:0] pix_reg;

    always_comb begin
        nb_sum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nb_sum = nb_sum + lapl_pkg::SUM_W'(win[k]);
            end
        end
        center_x8 = {win[4], 3'b000};
        diff      = center_x8 - nb_sum;
        if (center_x8 <= nb_sum) begin
            filt = '0;
        end else if (diff > lapl_pkg::SUM_W'(lapl_pkg::CHAN_MAX)) begin
            filt = lapl_pkg::CHAN_MAX;
        end else begin
            filt = diff[lapl_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            pix_reg <= ctl.border ? win[4] : filt;
        end
    end

    assign pix_out = pix_reg;

endmodule

### design/laplacian_edge_3x3_rgb.sv
// Top level of the 3x3 Laplacian RGB edge filter: counters, window, lanes, output.
// Depends on lapl_pkg, lapl_line_store and lapl_lane.
//
// Usage:
//  - s_ channel: one beat per raster pixel (s_drain = 0). After the last pixel of a
//    frame, send width+1 drain beats (s_drain = 1) to push out the last row and
//    column; drain beats sent while pixels are still expected are taken and dropped.
//  - m_ channel: one beat per pixel of the frame, in raster order, starting once one
//    row plus one column has come in. m_frame_end marks the last pixel; the next
//    s_ beat then starts a new frame.
//  - cfg_ channel: index 0 writes image_width, index 1 image_height (clamped to
//    3..MAX_WIDTH and 3..1024). A write to either register restarts the frame;
//    write only while idle. Other indexes are ignored. cfg_ready is always high.
//  - Throughput: one beat per clock; a new input beat is taken in every cycle
//    while the output register moves or is empty. A result reaches m_ through the
//    line store read at the edge that takes its input beat, then the window update,
//    then the lane arithmetic and output register.
//  - A stall on m_ready fills the three stages, then s_ready drops; nothing is lost.
//  - Reset (aresetn low, synchronous): size back to 640x480, frame position zero,
//    window cleared, pipeline empty. The line stores are not cleared.
module laplacian_edge_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lapl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lapl_pkg::SIZE_W-1:0]       cfg_data,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_drain,
    input  logic [lapl_pkg::CHAN_W-1:0]       s_red_in,
    input  logic [lapl_pkg::CHAN_W-1:0]       s_green_in,
    input  logic [lapl_pkg::CHAN_W-1:0]       s_blue_in,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lapl_pkg::CHAN_W-1:0]       m_red_out,
    output logic [lapl_pkg::CHAN_W-1:0]       m_green_out,
    output logic [lapl_pkg::CHAN_W-1:0]       m_blue_out,
    output logic                              m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);       // column index / line store address
    localparam int WW    = $clog2(MAX_WIDTH + 1);   // effective width value

    // clamp a written width to 3..MAX_WIDTH
    function automatic logic [WW-1:0] clamp_width(input logic [lapl_pkg::SIZE_W-1:0] v);
        logic [WW-1:0] res;
        if (v < lapl_pkg::MIN_SIZE) begin
            res = WW'(lapl_pkg::MIN_SIZE);
        end else if (32'(v) > MAX_WIDTH) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic logic [lapl_pkg::ROW_W-1:0] clamp_height(
        input logic [lapl_pkg::SIZE_W-1:0] v);
        logic [lapl_pkg::ROW_W-1:0] res;
        if (v < lapl_pkg::MIN_SIZE) begin
            res = lapl_pkg::ROW_W'(lapl_pkg::MIN_SIZE);
        end else if (32'(v) > lapl_pkg::HEIGHT_LIMIT) begin
            res = lapl_pkg::ROW_W'(lapl_pkg::HEIGHT_LIMIT);
        end else begin
            res = lapl_pkg::ROW_W'(v);
        end
        return res;
    endfunction

    // ---------------- config and frame position ----------------
    logic [WW-1:0]               width_reg;
    logic [lapl_pkg::ROW_W-1:0]  height_reg;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [lapl_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                        cfg_wr;
    logic                        cfg_restart;

    // ---------------- pipeline handshake ----------------
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic m_valid_reg, m_valid_next;
    logic c_free, b_move, b_free, a_move, a_free;
    logic in_beat, pixel_phase, a_load;

    // ---------------- per-beat decode ----------------
    logic [WW-1:0]   col_inc;
    logic            row_wrap;
    logic            emit, border, fend;
    lapl_pkg::pixel_t new_pix;

    // stage A: line store read done, item waiting to enter the window
    logic [COL_W-1:0] a_col_reg;
    lapl_pkg::pixel_t a_pix_reg;
    logic             a_emit_reg, a_border_reg, a_fend_reg;
    lapl_pkg::pixel_t top_pix, mid_pix;

    // stage B: window holds the neighborhood of the pending result
    lapl_pkg::pixel_t [2:0][2:0] win_reg;
    logic             b_border_reg, b_fend_reg;
    logic             fend_reg;

    lapl_pkg::chan_win_t red_win, green_win, blue_win;
    lapl_pkg::lane_ctl_t lane_ctl;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    // only the two size registers restart the frame
    assign cfg_restart = cfg_wr & ((cfg_index == lapl_pkg::CFG_IMAGE_WIDTH) |
                                   (cfg_index == lapl_pkg::CFG_IMAGE_HEIGHT));

    // ready chain from the output register back to the input
    assign c_free = ~m_valid_reg | m_ready;
    assign b_move = b_valid_reg & c_free;
    assign b_free = ~b_valid_reg | c_free;
    assign a_move = a_valid_reg & b_free;
    assign a_free = ~a_valid_reg | b_free;
    assign s_ready = a_free;

    assign in_beat     = s_valid & s_ready;
    assign pixel_phase = row_reg < height_reg;
    // a drain beat before all pixels are in is taken and dropped
    assign a_load      = in_beat & ~(pixel_phase & s_drain);

    always_comb begin
        new_pix = '0;
        if (pixel_phase) begin
            new_pix.red   = s_red_in;
            new_pix.green = s_green_in;
            new_pix.blue  = s_blue_in;
        end
        col_inc  = WW'(col_reg) + WW'(1);
        row_wrap = (col_inc == width_reg);
        // no result until one row plus one column are in
        emit   = ~((row_reg == '0) |
                   ((row_reg == lapl_pkg::ROW_W'(1)) & (col_reg == '0)));
        // column 0 here means the last column of the row above
        border = (col_reg == '0) | (col_reg == COL_W'(1)) |
                 (row_reg == lapl_pkg::ROW_W'(1)) | (row_reg >= height_reg);
        fend   = (row_reg == height_reg + lapl_pkg::ROW_W'(1)) & (col_reg == '0);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end else if (a_load) begin
            if (fend) begin
                col_next = '0;
                row_next = '0;
            end else if (row_wrap) begin
                col_next = '0;
                row_next = row_reg + lapl_pkg::ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_width(lapl_pkg::WIDTH_RESET);
            height_reg <= clamp_height(lapl_pkg::HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    lapl_pkg::CFG_IMAGE_WIDTH:  width_reg  <= clamp_width(cfg_data);
                    lapl_pkg::CFG_IMAGE_HEIGHT: height_reg <= clamp_height(cfg_data);
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores ----------------
    lapl_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (a_load),
        .rd_addr (col_reg),
        .wr_en   (a_move),
        .wr_addr (a_col_reg),
        .wr_pix  (a_pix_reg),
        .top_pix (top_pix),
        .mid_pix (mid_pix)
    );

    // ---------------- stage valids ----------------
    always_comb begin
        a_valid_next = a_load ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
        b_valid_next = a_move ? a_emit_reg : (b_move ? 1'b0 : b_valid_reg);
        m_valid_next = b_move ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // stage A payload
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_col_reg    <= col_reg;
            a_pix_reg    <= new_pix;
            a_emit_reg   <= emit;
            a_border_reg <= border;
            a_fend_reg   <= fend;
        end
    end

    // window shifts left by one column per beat; new column on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (a_move) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= a_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_border_reg <= a_border_reg;
            b_fend_reg   <= a_fend_reg;
        end
        if (b_move) begin
            fend_reg <= b_fend_reg;
        end
    end

    // ---------------- channel lanes ----------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                red_win[i*3+j]   = win_reg[i][j].red;
                green_win[i*3+j] = win_reg[i][j].green;
                blue_win[i*3+j]  = win_reg[i][j].blue;
            end
        end
        lane_ctl.load   = b_move;
        lane_ctl.border = b_border_reg;
    end

    lapl_lane u_lane_red (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .win     (red_win),
        .pix_out (m_red_out)
    );

    lapl_lane u_lane_green (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .win     (green_win),
        .pix_out (m_green_out)
    );

    lapl_lane u_lane_blue (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .win     (blue_win),
        .pix_out (m_blue_out)
    );

    // merged output beat: three lane registers plus frame end
    assign m_valid     = m_valid_reg;
    assign m_frame_end = fend_reg;

endmodule
